// File: rtl/owtp_pkg.sv
// owtp_pkg: shared types, codes and the crc-8 byte step for the probe poller
// no dependencies; imported by onewire_temp_probe_poller_unit
`default_nettype none

package owtp_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  CrcPoly      = 8'h8C;
  localparam logic [3:0]  LastByteIdx  = 4'd8;
  localparam logic [15:0] WaitReset    = 16'd200;
  localparam logic [15:0] MinRawReset  = 16'hFC90;
  localparam logic [15:0] MaxRawReset  = 16'd2000;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_CONV_WAIT = 2'd0,
    REG_MIN_RAW   = 2'd1,
    REG_MAX_RAW   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_POLL = 1'b0,
    ACT_BYTE = 1'b1
  } action_t;

  // dallas crc-8, reflected, one byte per call
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/onewire_temp_probe_poller_unit.sv
// onewire_temp_probe_poller_unit: 1-wire temperature probe scheduler and scratchpad checker
// depends on owtp_pkg (codes, crc-8 step)
//
// usage
//   in channel: one transaction per poll or scratchpad byte. in_tuser = 0 marks a poll
//   (now_ms, presence valid), in_tuser = 1 marks a scratchpad byte (data_byte valid).
//   out channel: exactly one transaction per input transaction, in order, carrying the
//   bus command to issue, the cached temperature (raw sixteenths, 0 while not valid)
//   and the valid flag in out_tuser.
//   cfg port: cfg_we writes register cfg_addr (0 conversion wait, 1 min raw, 2 max raw);
//   write only while no transaction is in flight.
// timing
//   the result is loaded into the output register at the accept edge.
//   throughput is one transaction per cycle while the output is not stalled; the crc byte step, the 32-bit elapsed-time
//   subtract and compare and the range compares all sit between the accept edge and the
//   output register.
// reset and stall
//   synchronous active-low reset clears the schedule, the read state, the cache and the
//   output valid, and loads the register defaults (200 ms, -880, 2000).
//   when out_tready is low with a result held, in_tready drops; the held result and all
//   state stay put until the result is taken, and in_tready returns in that same cycle.
`default_nettype none

module onewire_temp_probe_poller_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [owtp_pkg::InDataW-1:0]   in_tdata,  // now_ms[31:0], presence[32], data_byte[40:33]
  input  wire logic                           in_tuser,  // action
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [owtp_pkg::OutDataW-1:0]       out_tdata, // command[1:0], temperature[17:2]
  output logic                                out_tuser, // valid_res
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [owtp_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [owtp_pkg::CfgDataW-1:0]  cfg_wdata
);
  import owtp_pkg::*;

  // configuration registers
  logic [15:0] conv_wait_r;
  logic [15:0] min_raw_r;
  logic [15:0] max_raw_r;

  // schedule and read state
  logic        converting_r, converting_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic        reading_r, reading_nxt;
  logic [3:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic [15:0] cached_temp_r, cached_temp_nxt;
  logic        cached_ok_r, cached_ok_nxt;

  // output register
  logic        out_valid_r;
  cmd_t        out_cmd_r;
  logic [15:0] out_temp_r;
  logic        out_ok_r;

  // unpacked input fields
  logic [31:0] now_ms;
  logic        presence;
  logic [7:0]  data_byte;
  action_t     action;

  logic        in_accept;
  logic [31:0] elapsed;
  logic        wait_done;
  logic [15:0] raw_temp;
  logic        in_range;
  cmd_t        cmd_nxt;

  assign now_ms    = in_tdata[31:0];
  assign presence  = in_tdata[32];
  assign data_byte = in_tdata[40:33];
  assign action    = action_t'(in_tuser);

  // take a new transaction whenever the output register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // elapsed time wraps modulo 2^32
  assign elapsed   = now_ms - start_time_r;
  assign wait_done = elapsed >= {16'd0, conv_wait_r};

  assign raw_temp  = {high_byte_r, low_byte_r};
  assign in_range  = ($signed(raw_temp) >= $signed(min_raw_r)) &&
                     ($signed(raw_temp) <= $signed(max_raw_r));

  always_comb begin
    converting_nxt  = converting_r;
    start_time_nxt  = start_time_r;
    reading_nxt     = reading_r;
    byte_idx_nxt    = byte_idx_r;
    crc_nxt         = crc_r;
    low_byte_nxt    = low_byte_r;
    high_byte_nxt   = high_byte_r;
    cached_temp_nxt = cached_temp_r;
    cached_ok_nxt   = cached_ok_r;
    cmd_nxt         = CMD_NONE;
    unique case (action)
      ACT_POLL: begin
        // a poll abandons any unfinished read
        reading_nxt = 1'b0;
        if (!converting_r) begin
          if (presence) begin
            cmd_nxt        = CMD_START;
            start_time_nxt = now_ms;
            converting_nxt = 1'b1;
          end
        end else if (wait_done) begin
          if (presence) begin
            cmd_nxt      = CMD_READ;
            reading_nxt  = 1'b1;
            byte_idx_nxt = '0;
            crc_nxt      = '0;
          end
          converting_nxt = 1'b0;
        end
      end
      ACT_BYTE: begin
        // bytes outside a read are dropped
        if (reading_r) begin
          if (byte_idx_r < LastByteIdx) begin
            if (byte_idx_r == 4'd0) begin
              low_byte_nxt = data_byte;
            end
            if (byte_idx_r == 4'd1) begin
              high_byte_nxt = data_byte;
            end
            crc_nxt      = crc8_byte(crc_r, data_byte);
            byte_idx_nxt = byte_idx_r + 4'd1;
          end else begin
            // ninth byte is the crc
            if ((crc_r == data_byte) && in_range) begin
              cached_temp_nxt = raw_temp;
              cached_ok_nxt   = 1'b1;
            end
            reading_nxt  = 1'b0;
            byte_idx_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_wait_r <= WaitReset;
      min_raw_r   <= MinRawReset;
      max_raw_r   <= MaxRawReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CONV_WAIT: conv_wait_r <= cfg_wdata;
        REG_MIN_RAW:   min_raw_r   <= cfg_wdata;
        REG_MAX_RAW:   max_raw_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state update on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      converting_r  <= 1'b0;
      start_time_r  <= '0;
      reading_r     <= 1'b0;
      byte_idx_r    <= '0;
      crc_r         <= '0;
      low_byte_r    <= '0;
      high_byte_r   <= '0;
      cached_temp_r <= '0;
      cached_ok_r   <= 1'b0;
    end else if (in_accept) begin
      converting_r  <= converting_nxt;
      start_time_r  <= start_time_nxt;
      reading_r     <= reading_nxt;
      byte_idx_r    <= byte_idx_nxt;
      crc_r         <= crc_nxt;
      low_byte_r    <= low_byte_nxt;
      high_byte_r   <= high_byte_nxt;
      cached_temp_r <= cached_temp_nxt;
      cached_ok_r   <= cached_ok_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_cmd_r  <= cmd_nxt;
      out_temp_r <= cached_ok_nxt ? cached_temp_nxt : 16'd0;
      out_ok_r   <= cached_ok_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_temp_r, out_cmd_r};
  assign out_tuser  = out_ok_r;

`ifndef NO_ASSERTIONS
  // a conversion and a scratchpad read never run at once
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(converting_r && reading_r))
    else $error("conversion and read active together");

  // the byte counter never runs past the crc byte
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= LastByteIdx)
    else $error("scratchpad byte index out of range");

  // once valid, the cache stays valid
  a_ok_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cached_ok_r |=> cached_ok_r)
    else $error("cached valid flag dropped");

  // a reported temperature is zero unless the cache is valid
  a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_temp_r == 16'd0))
    else $error("nonzero temperature without valid flag");

  // a read command always opens a fresh read
  a_read_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && cmd_nxt == CMD_READ) |=> (reading_r && byte_idx_r == 4'd0 && crc_r == 8'd0))
    else $error("read command without read setup");
`endif

endmodule

`default_nettype wire
